>>> hdl/multi_list_linked_queue_unit_macros.svh
// assertion macros shared by the linked queue rtl
// expects clk and arst_n in the scope of every use
`ifndef MULTI_LIST_LINKED_QUEUE_UNIT_MACROS_SVH
`define MULTI_LIST_LINKED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define MLLQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mllq assertion failed");

// next-cycle implication
`define MLLQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mllq assertion failed");

`endif

>>> hdl/mllq_pkg.sv
// types, constants and helpers of the multi-list linked queue unit
// no dependencies
package mllq_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int NUM_LISTS   = 8;

	localparam int CMD_W   = 2;
	localparam int LIST_W  = 3;
	localparam int ENTRY_W = 4;
	localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
	localparam int STEP_W  = $clog2(NUM_ENTRIES + 1);

	typedef logic [LINK_W-1:0] link_t;

	localparam link_t LINK_NULL = LINK_W'(NUM_ENTRIES);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 2'd0,
		CMD_PREPEND = 2'd1,
		CMD_DEQUEUE = 2'd2,
		CMD_REMOVE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EMPTY_FAIL,
		OP_NOT_FOUND,
		OP_RD_HEAD,
		OP_TAKE,
		OP_INS_EMPTY,
		OP_TAIL_LINK,
		OP_APP_FIN,
		OP_PREP,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_RD_E,
		OP_UNLINK,
		OP_CLR_E
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic head_null;
		logic head_is_e;
		logic rd_is_e;
		logic rd_is_entry;
		logic step_max;
	} dp_stat_t;

	function automatic logic is_entry(input link_t x);
		return x < LINK_W'(NUM_ENTRIES);
	endfunction

endpackage

>>> hdl/mllq_ifs.sv
// request and response channel interfaces of the linked queue unit
// depends on mllq_pkg
interface mllq_req_if;
	import mllq_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [LIST_W-1:0]  list_id;
	logic [ENTRY_W-1:0] entry_id;

	modport source (output valid, output command, output list_id, output entry_id,
		input ready);
	modport sink (input valid, input command, input list_id, input entry_id,
		output ready);
endinterface

interface mllq_rsp_if;
	import mllq_pkg::*;

	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] result_entry;
	logic               status;

	modport source (output valid, output result_entry, output status, input ready);
	modport sink (input valid, input result_entry, input status, output ready);
endinterface

>>> hdl/mllq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mllq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hdl/mllq_ctrl.sv
// controller state machine of the linked queue unit
// depends on mllq_pkg and multi_list_linked_queue_unit_macros.svh
`include "multi_list_linked_queue_unit_macros.svh"

module mllq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mllq_pkg::dp_stat_t stat,
	output mllq_pkg::dp_ctl_t  ctl
);
	import mllq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_APPEND,
		S_TAKE,
		S_WALK,
		S_UNLINK,
		S_CLEAR,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.op       = OP_NONE;
		ctl.out_load = 1'b0;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_APPEND: begin
						if (stat.head_null) begin
							ctl.op  = OP_INS_EMPTY;
							state_d = S_RESP;
						end else begin
							ctl.op  = OP_TAIL_LINK;
							state_d = S_APPEND;
						end
					end
					CMD_PREPEND: begin
						ctl.op  = stat.head_null ? OP_INS_EMPTY : OP_PREP;
						state_d = S_RESP;
					end
					CMD_DEQUEUE: begin
						if (stat.head_null) begin
							ctl.op  = OP_EMPTY_FAIL;
							state_d = S_RESP;
						end else begin
							ctl.op  = OP_RD_HEAD;
							state_d = S_TAKE;
						end
					end
					CMD_REMOVE: begin
						if (stat.head_is_e) begin
							ctl.op  = OP_RD_HEAD;
							state_d = S_TAKE;
						end else if (stat.head_null) begin
							ctl.op  = OP_NOT_FOUND;
							state_d = S_RESP;
						end else begin
							ctl.op  = OP_WALK_START;
							state_d = S_WALK;
						end
					end
				endcase
			end
			S_APPEND: begin
				ctl.op  = OP_APP_FIN;
				state_d = S_RESP;
			end
			S_TAKE: begin
				ctl.op  = OP_TAKE;
				state_d = S_RESP;
			end
			S_WALK: begin
				if (stat.rd_is_e) begin
					ctl.op  = OP_RD_E;
					state_d = S_UNLINK;
				end else if (stat.step_max || !stat.rd_is_entry) begin
					ctl.op  = OP_NOT_FOUND;
					state_d = S_RESP;
				end else begin
					ctl.op = OP_WALK_STEP;
				end
			end
			S_UNLINK: begin
				ctl.op  = OP_UNLINK;
				state_d = S_CLEAR;
			end
			S_CLEAR: begin
				ctl.op  = OP_CLR_E;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MLLQ_ASSERT_IMPL(a_load_slot_free, ctl.out_load, !out_valid_q || out_ready)
	`MLLQ_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_q == S_DECODE)
endmodule

>>> hdl/mllq_dp.sv
// datapath of the linked queue unit: head and tail tables, link ram, walk and result regs
// depends on mllq_pkg, mllq_ram and multi_list_linked_queue_unit_macros.svh
`include "multi_list_linked_queue_unit_macros.svh"

module mllq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mllq_pkg::CMD_W-1:0]   in_command,
	input  logic [mllq_pkg::LIST_W-1:0]  in_list_id,
	input  logic [mllq_pkg::ENTRY_W-1:0] in_entry_id,
	input  mllq_pkg::dp_ctl_t            ctl,
	output mllq_pkg::dp_stat_t           stat,
	output logic [mllq_pkg::ENTRY_W-1:0] result_entry,
	output logic                         status
);
	import mllq_pkg::*;

	link_t               head_q [NUM_LISTS];
	link_t               tail_q [NUM_LISTS];
	cmd_t                cmd_q;
	logic [LIST_W-1:0]   list_q;
	logic [ENTRY_W-1:0]  entry_q;
	logic [ENTRY_W-1:0]  res_q;
	logic                status_q;
	link_t               t_q;
	logic [STEP_W-1:0]   step_q;
	logic [ENTRY_W-1:0]  out_entry_q;
	logic                out_status_q;

	link_t               cur_head;
	link_t               cur_tail;
	link_t               e_link;

	logic                ram_we;
	logic [ENTRY_W-1:0]  ram_waddr;
	link_t               ram_wdata;
	logic                ram_re;
	logic [ENTRY_W-1:0]  ram_raddr;
	link_t               ram_rdata;

	assign cur_head = head_q[list_q];
	assign cur_tail = tail_q[list_q];
	assign e_link   = LINK_W'(entry_q);

	assign stat.cmd         = cmd_q;
	assign stat.head_null   = !is_entry(cur_head);
	assign stat.head_is_e   = (cur_head == e_link);
	assign stat.rd_is_e     = (ram_rdata == e_link);
	assign stat.rd_is_entry = is_entry(ram_rdata);
	assign stat.step_max    = (step_q == STEP_W'(NUM_ENTRIES));

	assign result_entry = out_entry_q;
	assign status       = out_status_q;

	mllq_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NUM_ENTRIES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = entry_q;
		ram_wdata = LINK_NULL;
		ram_re    = 1'b0;
		ram_raddr = entry_q;
		case (ctl.op) inside
			OP_RD_HEAD, OP_WALK_START: begin
				ram_re    = 1'b1;
				ram_raddr = cur_head[ENTRY_W-1:0];
			end
			OP_WALK_STEP: begin
				ram_re    = 1'b1;
				ram_raddr = ram_rdata[ENTRY_W-1:0];
			end
			OP_RD_E: begin
				ram_re = 1'b1;
			end
			OP_TAKE: begin
				ram_we    = 1'b1;
				ram_waddr = cur_head[ENTRY_W-1:0];
			end
			OP_INS_EMPTY, OP_APP_FIN, OP_CLR_E: begin
				ram_we = 1'b1;
			end
			OP_TAIL_LINK: begin
				ram_we    = is_entry(cur_tail);
				ram_waddr = cur_tail[ENTRY_W-1:0];
				ram_wdata = e_link;
			end
			OP_PREP: begin
				ram_we    = 1'b1;
				ram_wdata = cur_head;
			end
			OP_UNLINK: begin
				ram_we    = 1'b1;
				ram_waddr = t_q[ENTRY_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// list heads and tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= LINK_NULL;
				tail_q[i] <= LINK_NULL;
			end
		end else begin
			case (ctl.op) inside
				OP_LOAD: begin
					list_q <= in_list_id;
				end
				OP_TAKE: begin
					if (is_entry(ram_rdata)) begin
						head_q[list_q] <= ram_rdata;
					end else begin
						head_q[list_q] <= LINK_NULL;
						tail_q[list_q] <= LINK_NULL;
					end
				end
				OP_INS_EMPTY: begin
					head_q[list_q] <= e_link;
					tail_q[list_q] <= e_link;
				end
				OP_APP_FIN: begin
					tail_q[list_q] <= e_link;
				end
				OP_PREP: begin
					head_q[list_q] <= e_link;
				end
				OP_UNLINK: begin
					if (cur_tail == e_link) begin
						tail_q[list_q] <= t_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// word fields, walk pointer and result
	always_ff @(posedge clk) begin
		case (ctl.op) inside
			OP_LOAD: begin
				cmd_q    <= cmd_t'(in_command);
				entry_q  <= in_entry_id;
				res_q    <= in_entry_id;
				status_q <= 1'b0;
			end
			OP_EMPTY_FAIL: begin
				res_q    <= '0;
				status_q <= 1'b1;
			end
			OP_NOT_FOUND: begin
				status_q <= 1'b1;
			end
			OP_TAKE: begin
				res_q <= cur_head[ENTRY_W-1:0];
			end
			OP_WALK_START: begin
				t_q    <= cur_head;
				step_q <= '0;
			end
			OP_WALK_STEP: begin
				t_q    <= ram_rdata;
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
		if (ctl.out_load) begin
			out_entry_q  <= res_q;
			out_status_q <= status_q;
		end
	end

	`MLLQ_ASSERT_IMPL(a_ram_one_access, ram_re, !ram_we)
	`MLLQ_ASSERT_IMPL(a_walk_bound, ctl.op == OP_WALK_STEP, !stat.step_max && stat.rd_is_entry)
	`MLLQ_ASSERT_IMPL(a_head_tail_pair, 1'b1, is_entry(cur_head) == is_entry(cur_tail))
endmodule

>>> hdl/multi_list_linked_queue_unit.sv
// top level of the multi-list linked queue unit
// depends on mllq_pkg, mllq_ifs, mllq_ctrl, mllq_dp
//
// channel  dir  fields
// req      in   command, list_id, entry_id
// rsp      out  result_entry, status
//
// one word in flight; req is ready only in idle, so a word waits until the last rsp is loaded
// rsp is loaded straight after decode for insert on an empty list, prepend, failed dequeue
// or remove on an empty list; via S_APPEND or S_TAKE for append to a non-empty list,
// dequeue and remove of head; remove of a later entry reads one link per cycle,
// then unlinks it if found; at most NUM_ENTRIES followed; a full rsp register stalls req
// reset empties every list at once; no clearing pass
module multi_list_linked_queue_unit (
	input logic       clk,
	input logic       arst_n,
	mllq_req_if.sink  req,
	mllq_rsp_if.source rsp
);
	import mllq_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	mllq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	mllq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_command  (req.command),
		.in_list_id  (req.list_id),
		.in_entry_id (req.entry_id),
		.ctl         (ctl),
		.stat        (stat),
		.result_entry(rsp.result_entry),
		.status      (rsp.status)
	);
endmodule

>>> dv/linked_queue_checker.sv
// watches the req and rsp channels of the multi-list linked queue unit,
// predicts every rsp word from the list commands taken and compares them
// depends on mllq_pkg and mllq_ifs
module linked_queue_checker (
	input  logic clk,
	input  logic arst_n,
	mllq_req_if  req,
	mllq_rsp_if  rsp,
	output int   failures,
	output int   pending,
	output int   results,
	output int   misses
);
	import mllq_pkg::*;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		logic               status;
	} rsp_word_t;

	link_t     nxt     [NUM_ENTRIES];
	link_t     head_of [NUM_LISTS];
	link_t     tail_of [NUM_LISTS];
	rsp_word_t rsp_due_q[$];
	int        errs = 0;
	int        seen = 0;
	int        empty_or_absent = 0;

	function automatic logic slot_ok(input link_t x);
		return x < link_t'(NUM_ENTRIES);
	endfunction

	function automatic link_t take_front(input logic [LIST_W-1:0] lst);
		link_t h;
		h = head_of[lst];
		if (!slot_ok(h))
			return LINK_NULL;
		head_of[lst] = nxt[h[ENTRY_W-1:0]];
		if (!slot_ok(head_of[lst])) begin
			head_of[lst] = LINK_NULL;
			tail_of[lst] = LINK_NULL;
		end
		nxt[h[ENTRY_W-1:0]] = LINK_NULL;
		return h;
	endfunction

	function automatic void apply_list_cmd(input cmd_t op, input logic [LIST_W-1:0] lst,
		input logic [ENTRY_W-1:0] ent, output rsp_word_t res);
		link_t e_ln;
		link_t h;
		link_t walk;
		int    steps;
		e_ln = link_t'(ent);
		res.entry = ent;
		res.status = 1'b0;
		case (op)
		CMD_DEQUEUE: begin
			h = take_front(lst);
			if (slot_ok(h)) begin
				res.entry = h[ENTRY_W-1:0];
			end else begin
				res.entry = '0;
				res.status = 1'b1;
			end
		end
		CMD_APPEND, CMD_PREPEND: begin
			if (!slot_ok(head_of[lst])) begin
				head_of[lst] = e_ln;
				tail_of[lst] = e_ln;
				nxt[ent] = LINK_NULL;
			end else if (op == CMD_APPEND) begin
				if (slot_ok(tail_of[lst]))
					nxt[tail_of[lst][ENTRY_W-1:0]] = e_ln;
				tail_of[lst] = e_ln;
				nxt[ent] = LINK_NULL;
			end else begin
				nxt[ent] = head_of[lst];
				head_of[lst] = e_ln;
			end
		end
		default: begin
			if (head_of[lst] == e_ln) begin
				void'(take_front(lst));
			end else begin
				// walk for the predecessor, bounded so a cycle cannot hang it
				walk = head_of[lst];
				steps = 0;
				while (slot_ok(walk) && nxt[walk[ENTRY_W-1:0]] != e_ln
					&& steps < NUM_ENTRIES) begin
					walk = nxt[walk[ENTRY_W-1:0]];
					steps++;
				end
				if (!slot_ok(walk) || nxt[walk[ENTRY_W-1:0]] != e_ln) begin
					res.status = 1'b1;
				end else begin
					nxt[walk[ENTRY_W-1:0]] = nxt[ent];
					if (tail_of[lst] == e_ln)
						tail_of[lst] = walk;
					nxt[ent] = LINK_NULL;
				end
			end
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++)
				nxt[i] = LINK_NULL;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_of[i] = LINK_NULL;
				tail_of[i] = LINK_NULL;
			end
			rsp_due_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen++;
				if (rsp_due_q.size() == 0) begin
					errs++;
					$display("%0t: rsp word with nothing expected, got entry %0d status %0d",
						$time, rsp.result_entry, rsp.status);
				end else begin
					want = rsp_due_q.pop_front();
					if (want.status)
						empty_or_absent++;
					if (rsp.result_entry !== want.entry) begin
						errs++;
						$display("%0t: result_entry mismatch, expected %0d, got %0d",
							$time, want.entry, rsp.result_entry);
					end
					if (rsp.status !== want.status) begin
						errs++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready) begin
				apply_list_cmd(cmd_t'(req.command), req.list_id, req.entry_id, want);
				rsp_due_q.push_back(want);
			end
		end
		pending <= rsp_due_q.size();
		failures <= errs;
		results <= seen;
		misses <= empty_or_absent;
	end

endmodule

>>> dv/testbench.sv
// stimulus and verdict for the multi-list linked queue unit: directed list
// commands, then random well-formed sequences with idling and back-pressure
// depends on mllq_pkg, mllq_ifs, multi_list_linked_queue_unit, linked_queue_checker
module testbench;
	import mllq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RX_HOLD     = 80;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   results;
	int   misses;
	int   words_sent = 0;
	int   cycle_count = 0;
	bit   tx_quiet = 0;
	bit   rx_quiet = 0;
	bit   rx_hold_req = 0;
	int   hold_left = 0;
	int   chain  [NUM_LISTS][$];
	int   holder [NUM_ENTRIES];

	mllq_req_if req_ch();
	mllq_rsp_if rsp_ch();

	multi_list_linked_queue_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	linked_queue_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.failures(failures),
		.pending (pending),
		.results (results),
		.misses  (misses)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// rsp side: random stalls, a quiet stretch, and one long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_hold_req) begin
				rx_hold_req = 0;
				hold_left = RX_HOLD;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= rx_quiet || ($urandom_range(99) >= 23);
			end
		end
	end

	task automatic send_word(input cmd_t c, input int l, input int e);
		int gap;
		gap = 0;
		if (!tx_quiet)
			while ($urandom_range(99) < 23)
				gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= c;
		req_ch.list_id <= LIST_W'(l);
		req_ch.entry_id <= ENTRY_W'(e);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	// picks a list command, mostly well-formed against the tracked occupancy
	task automatic send_random_cmd();
		int   l;
		int   pick;
		int   e;
		int   cand;
		int   k;
		bit   found;
		cmd_t c;
		l = ($urandom_range(99) < 55) ? $urandom_range(1, 0) : $urandom_range(NUM_LISTS - 1);
		pick = $urandom_range(99);
		e = $urandom_range(NUM_ENTRIES - 1);
		c = CMD_DEQUEUE;
		if (pick < 50) begin
			found = 0;
			for (k = 0; k < NUM_ENTRIES && !found; k++) begin
				cand = (e + k) % NUM_ENTRIES;
				if (holder[cand] < 0) begin
					e = cand;
					found = 1;
				end
			end
			if (found) begin
				holder[e] = l;
				if (pick < 30) begin
					c = CMD_APPEND;
					chain[l].push_back(e);
				end else begin
					c = CMD_PREPEND;
					chain[l].push_front(e);
				end
			end else begin
				pick = 60;
			end
		end
		if (pick >= 50 && pick < 75) begin
			c = CMD_DEQUEUE;
			if (chain[l].size() > 0) begin
				holder[chain[l][0]] = -1;
				void'(chain[l].pop_front());
			end
		end else if (pick >= 75) begin
			c = CMD_REMOVE;
			if ($urandom_range(99) < 70 && chain[l].size() > 0)
				e = chain[l][$urandom_range(chain[l].size() - 1)];
			if (holder[e] == l) begin
				for (k = 0; k < chain[l].size(); k++)
					if (chain[l][k] == e) begin
						chain[l].delete(k);
						break;
					end
				holder[e] = -1;
			end
		end
		send_word(c, l, e);
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = CMD_APPEND;
		req_ch.list_id = '0;
		req_ch.entry_id = '0;
		arst_n = 1'b0;
		for (int i = 0; i < NUM_ENTRIES; i++)
			holder[i] = -1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty list, head/middle/tail removal, absent entry, field extremes
		send_word(CMD_DEQUEUE, 0, 15);
		send_word(CMD_REMOVE, 7, 15);
		send_word(CMD_APPEND, 7, 15);
		send_word(CMD_APPEND, 7, 0);
		send_word(CMD_PREPEND, 7, 8);
		send_word(CMD_APPEND, 7, 7);
		send_word(CMD_REMOVE, 7, 0);
		send_word(CMD_REMOVE, 7, 7);
		send_word(CMD_APPEND, 7, 3);
		send_word(CMD_REMOVE, 7, 8);
		send_word(CMD_REMOVE, 7, 9);
		send_word(CMD_DEQUEUE, 7, 0);
		send_word(CMD_DEQUEUE, 7, 5);
		send_word(CMD_DEQUEUE, 7, 10);
		// re-insert of a queued entry, self loop, bounded walk
		send_word(CMD_APPEND, 0, 5);
		send_word(CMD_APPEND, 0, 5);
		send_word(CMD_PREPEND, 0, 5);
		send_word(CMD_REMOVE, 0, 6);
		send_word(CMD_REMOVE, 0, 5);
		send_word(CMD_DEQUEUE, 0, 0);
		send_word(CMD_DEQUEUE, 0, 15);
		// entry held by another list, two-entry tail removal
		send_word(CMD_APPEND, 3, 10);
		send_word(CMD_PREPEND, 3, 11);
		send_word(CMD_REMOVE, 2, 11);
		send_word(CMD_REMOVE, 3, 10);
		send_word(CMD_DEQUEUE, 3, 4);

		repeat (350) send_random_cmd();

		tx_quiet = 1;
		rx_quiet = 1;
		repeat (150) send_random_cmd();

		// rsp side holds off while req keeps coming, then wait for a full drain
		rx_hold_req = 1;
		repeat (40) send_random_cmd();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		tx_quiet = 0;
		rx_quiet = 0;

		repeat (360) send_random_cmd();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);

		$display("run covered %0d list commands and %0d rsp words, %0d of them empty or absent",
			words_sent, results, misses);
		if (failures == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
